// ===== rtl/core/vp8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8d_pkg
// Shared types and constants of the RTP VP8 depacketiser.
// ----------------------------------------------------------------------------
package vp8d_pkg;

    // Field widths
    localparam int unsigned LEN_W  = 21;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FLAG_W = 6;
    localparam int unsigned PID_W  = 15;
    localparam int unsigned TID_W  = 2;
    localparam int unsigned KIDX_W = 5;

    // Hard ceiling on payload bytes per frame
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 21'd1048576;

    // Capacity register value after reset
    localparam logic [LEN_W-1:0] CAP_RESET = 21'd1048576;

    // Frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;

    // Descriptor view handed from the parser to the frame logic.
    // Field values are those in force after the current item.
    typedef struct packed {
        logic              is_data;
        logic [FLAG_W-1:0] flags;
        logic [PID_W-1:0]  pid;
        logic [BYTE_W-1:0] tl0;
        logic [TID_W-1:0]  tid;
        logic [KIDX_W-1:0] keyidx;
    } desc_t;

endpackage

// ===== rtl/core/vp8d_desc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8d_desc_parser
// Walks the VP8 payload descriptor one byte per item and keeps the parsed
// fields (picture ID, TL0PICIDX, TID, KEYIDX and the packet flags).
// ----------------------------------------------------------------------------
module vp8d_desc_parser
    import vp8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] packet_byte,
    input  logic              packet_end,
    output desc_t             desc
);

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_EXT  = 3'd1,
        PH_PID  = 3'd2,
        PH_PID2 = 3'd3,
        PH_TL0  = 3'd4,
        PH_TK   = 3'd5,
        PH_DATA = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [3:0]        ext_reg, ext_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [PID_W-1:0]  pid_reg, pid_next;
    logic [BYTE_W-1:0] tl0_reg, tl0_next;
    logic [TID_W-1:0]  tid_reg, tid_next;
    logic [KIDX_W-1:0] keyidx_reg, keyidx_next;

    // Next phase after the extension byte (0), picture ID (1) or TL0 (2)
    function automatic phase_t phase_after(input logic [3:0] ext, input logic [1:0] stage);
        phase_t ph;
        if (stage == 2'd0 && ext[3])
            ph = PH_PID;
        else if (stage <= 2'd1 && ext[2])
            ph = PH_TL0;
        else if (ext[1:0] != 2'b00)
            ph = PH_TK;
        else
            ph = PH_DATA;
        return ph;
    endfunction

    // Descriptor decode for the byte on hand
    always_comb
    begin
        phase_next  = phase_reg;
        ext_next    = ext_reg;
        flags_next  = flags_reg;
        pid_next    = pid_reg;
        tl0_next    = tl0_reg;
        tid_next    = tid_reg;
        keyidx_next = keyidx_reg;
        case (phase_reg)
            PH_HDR:
            begin
                flags_next = {{(FLAG_W-1){1'b0}}, packet_byte[5]};
                phase_next = packet_byte[7] ? PH_EXT : PH_DATA;
            end
            PH_EXT:
            begin
                ext_next   = packet_byte[7:4];
                phase_next = phase_after(packet_byte[7:4], 2'd0);
            end
            PH_PID:
            begin
                flags_next[1] = 1'b1;
                if (packet_byte[7])
                begin
                    pid_next   = {packet_byte[6:0], 8'h00};
                    phase_next = PH_PID2;
                end
                else
                begin
                    pid_next   = {8'h00, packet_byte[6:0]};
                    phase_next = phase_after(ext_reg, 2'd1);
                end
            end
            PH_PID2:
            begin
                pid_next   = pid_reg | {7'h00, packet_byte};
                phase_next = phase_after(ext_reg, 2'd1);
            end
            PH_TL0:
            begin
                flags_next[2] = 1'b1;
                tl0_next      = packet_byte;
                phase_next    = phase_after(ext_reg, 2'd2);
            end
            PH_TK:
            begin
                if (ext_reg[1])
                begin
                    flags_next[3] = 1'b1;
                    tid_next      = packet_byte[7:6];
                end
                if (ext_reg[0])
                begin
                    flags_next[4] = 1'b1;
                    keyidx_next   = packet_byte[4:0];
                end
                if (packet_byte[5])
                    flags_next[5] = 1'b1;
                phase_next = PH_DATA;
            end
            default:
                phase_next = PH_DATA;
        endcase
        // a new descriptor follows every packet end
        if (packet_end)
            phase_next = PH_HDR;
    end

    // Descriptor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            ext_reg    <= 4'h0;
            flags_reg  <= '0;
            pid_reg    <= '0;
            tl0_reg    <= '0;
            tid_reg    <= '0;
            keyidx_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            ext_reg    <= ext_next;
            flags_reg  <= flags_next;
            pid_reg    <= pid_next;
            tl0_reg    <= tl0_next;
            tid_reg    <= tid_next;
            keyidx_reg <= keyidx_next;
        end
    end

    // bytes past PH_TK are all payload
    assign desc.is_data = (phase_reg == PH_DATA);
    assign desc.flags   = flags_next;
    assign desc.pid     = pid_next;
    assign desc.tl0     = tl0_next;
    assign desc.tid     = tid_next;
    assign desc.keyidx  = keyidx_next;

endmodule

// ===== rtl/core/vp8_rtp_depacketizer.sv =====
`timescale 1ns / 1ps
// The result of an accepted byte is loaded into the output register in the cycle after it is taken.
// Throughput: one byte per cycle while in_ready is high; the single-pass descriptor and count logic
// sits between the input port and the output register.
// in_ready stays high while the output register is empty or being taken.
// Reset (rst_n, asynchronous) clears descriptor state, counters and the output valid flag.
// ----------------------------------------------------------------------------
// vp8_rtp_depacketizer
// Strips the VP8 payload descriptor from each RTP packet, forwards payload
// bytes, and reports frame status, length and descriptor fields at frame end.
// ----------------------------------------------------------------------------
module vp8_rtp_depacketizer
    import vp8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    // input items
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] packet_byte,
    input  logic              packet_end,
    input  logic              frame_end,
    // result items
    output logic              out_valid,
    input  logic              out_ready,
    output logic              payload_valid,
    output logic [BYTE_W-1:0] payload_out,
    output logic              frame_done,
    output logic [1:0]        frame_status,
    output logic [LEN_W-1:0]  frame_length,
    output logic [FLAG_W-1:0] frame_flags,
    output logic [PID_W-1:0]  picture_number,
    output logic [BYTE_W-1:0] base_layer_index,
    output logic [TID_W-1:0]  temporal_layer,
    output logic [KIDX_W-1:0] key_frame_index
);

    logic              step;
    logic              fend;
    desc_t             desc;
    logic [LEN_W-1:0]  cap;

    logic [LEN_W-1:0]  cap_reg;
    logic              seen_reg, seen_next;
    logic [LEN_W-1:0]  count_reg, count_next, count_out;
    logic [1:0]        err_reg, err_next, err_out;
    logic              pv;
    logic              res_next;

    logic              out_valid_reg;
    logic              pv_reg;
    logic [BYTE_W-1:0] pout_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [BYTE_W-1:0] tl0_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [KIDX_W-1:0] keyidx_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;
    assign fend     = packet_end && frame_end;
    assign cap      = (cap_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : cap_reg;

    vp8d_desc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .packet_byte (packet_byte),
        .packet_end  (packet_end),
        .desc        (desc)
    );

    // Payload admission, sticky error and packet-end checks
    always_comb
    begin
        seen_next  = seen_reg;
        count_next = count_reg;
        err_next   = err_reg;
        pv         = 1'b0;
        if (desc.is_data)
        begin
            seen_next = 1'b1;
            if (err_reg == ST_OK)
            begin
                if (count_reg < cap)
                begin
                    pv         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                    err_next = ST_CAPACITY;
            end
        end
        if (packet_end)
        begin
            if (!seen_next && err_next == ST_OK)
                err_next = ST_MALFORMED;
            seen_next = 1'b0;
        end
        count_out = count_next;
        err_out   = err_next;
        // summary taken, frame totals restart
        if (fend)
        begin
            count_next = '0;
            err_next   = ST_OK;
        end
        res_next = pv || fend;
    end

    // Capacity register and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            seen_reg  <= 1'b0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (step)
            begin
                seen_reg  <= seen_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= res_next;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pv_reg     <= pv;
            pout_reg   <= pv ? packet_byte : '0;
            done_reg   <= fend;
            status_reg <= fend ? err_out : '0;
            length_reg <= fend ? count_out : '0;
            flags_reg  <= fend ? desc.flags : '0;
            pid_reg    <= fend ? desc.pid : '0;
            tl0_reg    <= fend ? desc.tl0 : '0;
            tid_reg    <= fend ? desc.tid : '0;
            keyidx_reg <= fend ? desc.keyidx : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign payload_valid    = pv_reg;
    assign payload_out      = pout_reg;
    assign frame_done       = done_reg;
    assign frame_status     = status_reg;
    assign frame_length     = length_reg;
    assign frame_flags      = flags_reg;
    assign picture_number   = pid_reg;
    assign base_layer_index = tl0_reg;
    assign temporal_layer   = tid_reg;
    assign key_frame_index  = keyidx_reg;

endmodule

// ===== dv/vp8_rtp_depacketizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vp8_rtp_depacketizer_test
// Self-checking bench for the RTP VP8 depacketiser. A queue-fed driver sends
// packet bytes over valid/ready, and a monitor predicts each result item from
// its own descriptor parser and frame counter and compares it field by field.
// Phases change the frame capacity and the idling of either side.
// ----------------------------------------------------------------------------
module vp8_rtp_depacketizer_test;
    import vp8d_pkg::*;

    // Descriptor parse position within a packet
    typedef enum logic [2:0] {
        PH_HDR, PH_EXT, PH_PID, PH_PID2, PH_TL0, PH_TK, PH_DATA
    } desc_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pkt_last;
        logic              frm_last;
    } packet_item_t;

    typedef struct packed {
        logic              pv;
        logic [BYTE_W-1:0] pout;
        logic              done;
        logic [1:0]        status;
        logic [LEN_W-1:0]  len;
        logic [FLAG_W-1:0] flags;
        logic [PID_W-1:0]  pid;
        logic [BYTE_W-1:0] tl0;
        logic [TID_W-1:0]  tid;
        logic [KIDX_W-1:0] kidx;
    } frame_result_t;

    localparam int NUM_PHASES = 8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [LEN_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] packet_byte = '0;
    logic              packet_end = 1'b0;
    logic              frame_end = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_out;
    logic              frame_done;
    logic [1:0]        frame_status;
    logic [LEN_W-1:0]  frame_length;
    logic [FLAG_W-1:0] frame_flags;
    logic [PID_W-1:0]  picture_number;
    logic [BYTE_W-1:0] base_layer_index;
    logic [TID_W-1:0]  temporal_layer;
    logic [KIDX_W-1:0] key_frame_index;

    packet_item_t  item_q[$];
    frame_result_t result_q[$];
    logic          in_taken = 1'b0;
    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   mismatch_count = 0;

    // Predictor state
    logic [LEN_W-1:0]  capacity;
    desc_phase_t       parse_phase;
    logic [3:0]        ext_bits;
    logic              got_payload;
    logic [LEN_W-1:0]  frame_bytes;
    logic [1:0]        frame_err;
    logic [FLAG_W-1:0] pkt_flags;
    logic [PID_W-1:0]  pid_val;
    logic [BYTE_W-1:0] tl0_val;
    logic [TID_W-1:0]  tid_val;
    logic [KIDX_W-1:0] kidx_val;

    // Phase plan: capacity, sender idle and receiver stall per hundred, bytes
    int unsigned phase_cap[NUM_PHASES]   = '{1048576, 1, 24, 7, 1048575, 60, 3, 1048576};
    int unsigned phase_send[NUM_PHASES]  = '{0, 86, 0, 36, 86, 0, 36, 0};
    int unsigned phase_stall[NUM_PHASES] = '{0, 0, 86, 36, 0, 0, 36, 86};
    int unsigned phase_bytes[NUM_PHASES] = '{250, 150, 250, 250, 200, 250, 200, 100};

    vp8_rtp_depacketizer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .packet_byte      (packet_byte),
        .packet_end       (packet_end),
        .frame_end        (frame_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .payload_valid    (payload_valid),
        .payload_out      (payload_out),
        .frame_done       (frame_done),
        .frame_status     (frame_status),
        .frame_length     (frame_length),
        .frame_flags      (frame_flags),
        .picture_number   (picture_number),
        .base_layer_index (base_layer_index),
        .temporal_layer   (temporal_layer),
        .key_frame_index  (key_frame_index)
    );

    always #5 clk = ~clk;

    // Next descriptor field after ext (0), picture ID (1) or TL0PICIDX (2)
    function automatic desc_phase_t next_phase(logic [3:0] ext, int unsigned stage);
        if (stage == 0 && ext[3])
            return PH_PID;
        if (stage <= 1 && ext[2])
            return PH_TL0;
        if (ext[1:0] != 2'b00)
            return PH_TK;
        return PH_DATA;
    endfunction

    task automatic clear_parser();
        capacity    = CAP_RESET;
        parse_phase = PH_HDR;
        ext_bits    = '0;
        got_payload = 1'b0;
        frame_bytes = '0;
        frame_err   = ST_OK;
        pkt_flags   = '0;
        pid_val     = '0;
        tl0_val     = '0;
        tid_val     = '0;
        kidx_val    = '0;
    endtask

    // Parse one accepted byte and work out the result item it causes, if any
    task automatic depacketize_byte(input packet_item_t it, output bit has_result,
                                    output frame_result_t r);
        logic [LEN_W-1:0]  limit;
        logic              fe;
        logic              pv;
        logic [BYTE_W-1:0] pout;
        limit = (capacity > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : capacity;
        fe    = it.pkt_last && it.frm_last;
        pv    = 1'b0;
        pout  = '0;
        case (parse_phase)
            PH_HDR:
            begin
                pkt_flags   = {5'b0, it.data[5]};
                parse_phase = it.data[7] ? PH_EXT : PH_DATA;
            end
            PH_EXT:
            begin
                ext_bits    = it.data[7:4];
                parse_phase = next_phase(ext_bits, 0);
            end
            PH_PID:
            begin
                pkt_flags[1] = 1'b1;
                if (it.data[7])
                begin
                    pid_val     = {it.data[6:0], 8'h00};
                    parse_phase = PH_PID2;
                end
                else
                begin
                    pid_val     = {8'h00, it.data[6:0]};
                    parse_phase = next_phase(ext_bits, 1);
                end
            end
            PH_PID2:
            begin
                pid_val     = pid_val | {7'b0, it.data};
                parse_phase = next_phase(ext_bits, 1);
            end
            PH_TL0:
            begin
                pkt_flags[2] = 1'b1;
                tl0_val      = it.data;
                parse_phase  = next_phase(ext_bits, 2);
            end
            PH_TK:
            begin
                if (ext_bits[1])
                begin
                    pkt_flags[3] = 1'b1;
                    tid_val      = it.data[7:6];
                end
                if (ext_bits[0])
                begin
                    pkt_flags[4] = 1'b1;
                    kidx_val     = it.data[4:0];
                end
                if (it.data[5])
                    pkt_flags[5] = 1'b1;
                parse_phase = PH_DATA;
            end
            default:
            begin
                // payload: dropped once an error holds or the frame is full
                parse_phase = PH_DATA;
                got_payload = 1'b1;
                if (frame_err == ST_OK)
                begin
                    if (frame_bytes < limit)
                    begin
                        pv          = 1'b1;
                        pout        = it.data;
                        frame_bytes = frame_bytes + 1'b1;
                    end
                    else
                        frame_err = ST_CAPACITY;
                end
            end
        endcase

        // packet with no payload byte is malformed
        if (it.pkt_last)
        begin
            if (!got_payload && frame_err == ST_OK)
                frame_err = ST_MALFORMED;
            parse_phase = PH_HDR;
            got_payload = 1'b0;
        end

        has_result = pv || fe;
        r      = '0;
        r.pv   = pv;
        r.pout = pout;
        if (fe)
        begin
            r.done      = 1'b1;
            r.status    = frame_err;
            r.len       = frame_bytes;
            r.flags     = pkt_flags;
            r.pid       = pid_val;
            r.tl0       = tl0_val;
            r.tid       = tid_val;
            r.kidx      = kidx_val;
            frame_bytes = '0;
            frame_err   = ST_OK;
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Driver: next item at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        packet_item_t nxt;
        if (!in_valid || in_taken)
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = item_q.pop_front();
                in_valid    <= 1'b1;
                packet_byte <= nxt.data;
                packet_end  <= nxt.pkt_last;
                frame_end   <= nxt.frm_last;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: check taken results, predict from taken items
    always @(posedge clk)
    begin
        frame_result_t want;
        frame_result_t calc;
        bit            has;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result item with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("payload_valid", want.pv, payload_valid);
                    check_field("payload_out", want.pout, payload_out);
                    check_field("frame_done", want.done, frame_done);
                    check_field("frame_status", want.status, frame_status);
                    check_field("frame_length", want.len, frame_length);
                    check_field("frame_flags", want.flags, frame_flags);
                    check_field("picture_number", want.pid, picture_number);
                    check_field("base_layer_index", want.tl0, base_layer_index);
                    check_field("temporal_layer", want.tid, temporal_layer);
                    check_field("key_frame_index", want.kidx, key_frame_index);
                end
            end
            if (in_valid && in_ready)
            begin
                depacketize_byte('{packet_byte, packet_end, frame_end}, has, calc);
                if (has)
                    result_q.push_back(calc);
            end
        end
    end

    task automatic push_item(logic [7:0] data, logic pkt_last, logic frm_last);
        item_q.push_back('{data, pkt_last, frm_last});
    endtask

    // One frame of 1..4 packets: mostly well formed, some cut short, some noise
    task automatic queue_frame(output int unsigned n_bytes);
        logic [7:0]  pkt[$];
        logic [7:0]  hdr;
        logic [7:0]  ext;
        logic [7:0]  pid0;
        int unsigned n_pkts;
        int unsigned kind;
        int unsigned keep;
        int unsigned pay_len;
        int unsigned last_idx;
        n_bytes = 0;
        n_pkts  = $urandom_range(1, 4);
        for (int p = 0; p < n_pkts; p++)
        begin
            pkt.delete();
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 6))
                    pkt.push_back(8'($urandom_range(255)));
            end
            else
            begin
                hdr    = 8'($urandom_range(255));
                hdr[7] = ($urandom_range(3) != 0);
                pkt.push_back(hdr);
                if (hdr[7])
                begin
                    ext = 8'($urandom_range(255));
                    pkt.push_back(ext);
                    if (ext[7])
                    begin
                        pid0 = 8'($urandom_range(255));
                        pkt.push_back(pid0);
                        if (pid0[7])
                            pkt.push_back(8'($urandom_range(255)));
                    end
                    if (ext[6])
                        pkt.push_back(8'($urandom_range(255)));
                    if (ext[5] || ext[4])
                        pkt.push_back(8'($urandom_range(255)));
                end
                if (kind < 18)
                begin
                    // ends inside its descriptor or right after it
                    keep = $urandom_range(1, pkt.size());
                    while (pkt.size() > keep)
                        void'(pkt.pop_back());
                end
                else
                begin
                    pay_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
                    repeat (pay_len)
                        pkt.push_back(8'($urandom_range(255)));
                end
            end
            last_idx = pkt.size() - 1;
            foreach (pkt[i])
            begin
                if (i == last_idx)
                    push_item(pkt[i], 1'b1, p == n_pkts - 1);
                else
                    push_item(pkt[i], 1'b0, 1'($urandom_range(1)));
            end
            n_bytes += pkt.size();
        end
    endtask

    // Sender holds off until every item is taken and every result is back;
    // sampled at the rising edge, clear of the driver's falling-edge updates
    task automatic wait_idle();
        while (item_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(logic [LEN_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        capacity  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int unsigned queued;
        int unsigned n;
        clear_parser();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames at reset capacity
        // all descriptor fields present, 15-bit picture ID, all-ones bytes but a zero TL0PICIDX
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        // two bare packets, flags cleared per packet
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h20, 1'b0, 1'b0);
        push_item(8'h7F, 1'b1, 1'b1);
        // packet with no payload
        push_item(8'h10, 1'b1, 1'b1);
        // packet ending inside its descriptor
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        // 7-bit picture ID
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h05, 1'b0, 1'b0);
        push_item(8'h01, 1'b1, 1'b1);
        // frame end without packet end is ignored
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hAA, 1'b0, 1'b1);
        push_item(8'h55, 1'b1, 1'b1);
        // TID byte without KEYIDX
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h20, 1'b0, 1'b0);
        push_item(8'hC0, 1'b0, 1'b0);
        push_item(8'h11, 1'b1, 1'b1);

        // random frames, one capacity and idling mix per phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            write_capacity(LEN_W'(phase_cap[ph]));
            send_idle_pct = phase_send[ph];
            stall_pct     = phase_stall[ph];
            queued        = 0;
            while (queued < phase_bytes[ph])
            begin
                queue_frame(n);
                queued += n;
            end
        end
        wait_idle();
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && result_q.size() == 0)
            $display("vp8_rtp_depacketizer_test OK");
        else
            $display("vp8_rtp_depacketizer_test NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("vp8_rtp_depacketizer_test NOT OK");
        $finish;
    end

endmodule
